@@ sv/u8v_pkg.sv @@
`timescale 1ns / 1ps
// Package for the UTF-8 lossy validator.
// Holds widths, byte codes, the judgement code and the controller/datapath structs.
// No dependencies.
package u8v_pkg;

  // width of the running input offset
  localparam int OFFSET_WIDTH = 32;
  // width of the reported offset field
  localparam int OUT_OFS_W = 32;
  // lead plus up to three continuation bytes
  localparam int BUF_DEPTH = 4;

  // replacement character U+FFFD
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;
  // surrogate lead
  localparam logic [7:0] SURR_LEAD = 8'hED;
  localparam logic [7:0] SURR_LO = 8'hA0;
  localparam logic [7:0] SURR_HI = 8'hBF;
  // continuation byte tag in bits 7:6
  localparam logic [1:0] CONT_TAG = 2'b10;

  // outcome of judging the buffered bytes
  typedef enum logic [1:0] {
    V_NEED = 2'd0,
    V_GOOD = 2'd1,
    V_BAD  = 2'd2
  } verdict_t;

  // controller -> datapath
  typedef struct packed {
    logic       take;      // load the input word into the buffer
    logic       emit;      // write one output word
    logic [1:0] idx;       // byte of the current sequence being written
    logic       emit_end;  // last word of this sequence: advance the buffer
  } u8v_cmd_t;

  // datapath -> controller
  typedef struct packed {
    verdict_t   verdict;   // judgement, with truncation on the final word folded in
    logic [2:0] seq_len;   // length of a good sequence
    logic       drains;    // advancing empties the buffer
    logic       out_free;  // output register can take a word this cycle
  } u8v_stat_t;

endpackage

@@ sv/u8v_in_if.sv @@
`timescale 1ns / 1ps
// Input channel: valid/ready handshake carrying one text byte and an end mark.
// Depends on nothing.
interface u8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

@@ sv/u8v_out_if.sv @@
`timescale 1ns / 1ps
// Output channel: valid/ready handshake carrying one cleaned byte and string status.
// Depends on u8v_pkg for the offset width.
interface u8v_out_if;
  logic                            valid;
  logic                            ready;
  logic [7:0]                      out_byte;
  logic                            is_replacement;
  logic                            out_last;
  logic                            all_valid;
  logic [u8v_pkg::OUT_OFS_W-1:0]   first_bad_offset;

  modport source (output valid, output out_byte, output is_replacement, output out_last,
                  output all_valid, output first_bad_offset, input ready);
  modport sink (input valid, input out_byte, input is_replacement, input out_last,
                input all_valid, input first_bad_offset, output ready);
endinterface

@@ sv/u8v_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: takes input words and sequences the output words of each judged sequence.
// Depends on u8v_pkg for the command and status structs.
module u8v_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  u8v_pkg::u8v_stat_t stat,
  output u8v_pkg::u8v_cmd_t  cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t     state;
  logic [1:0] idx;
  logic [1:0] emit_last_idx;
  logic       idx_end;

  // a failure writes three replacement bytes, a good sequence its own length
  assign emit_last_idx = (stat.verdict == u8v_pkg::V_BAD) ? 2'd2 : 2'(stat.seq_len - 3'd1);
  assign idx_end       = (idx == emit_last_idx);

  assign in_ready = (state == ST_IDLE);

  // commands
  always_comb begin
    cmd.take     = (state == ST_IDLE) && in_valid;
    cmd.emit     = (state == ST_EMIT) && (stat.verdict != u8v_pkg::V_NEED) && stat.out_free;
    cmd.idx      = idx;
    cmd.emit_end = cmd.emit && idx_end;
  end

  // state and byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= 2'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          idx <= 2'd0;
          if (cmd.take) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (stat.verdict == u8v_pkg::V_NEED) begin
            state <= ST_IDLE;
          end else if (cmd.emit) begin
            if (idx_end) begin
              idx <= 2'd0;
              if (stat.drains) state <= ST_IDLE;
            end else begin
              idx <= idx + 2'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // the byte counter never runs past the end of a sequence
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> idx <= emit_last_idx)
    else $error("byte index past end of sequence");

  // a buffer judged to need more sends the controller back to take a new word
  a_take_after_need: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && stat.verdict == u8v_pkg::V_NEED) |=> state == ST_IDLE)
    else $error("controller did not return for more input");

  // a sequence that does not drain the buffer is judged again
  a_rejudge: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_end && !stat.drains) |=> (state == ST_EMIT && idx == 2'd0))
    else $error("remaining bytes not re-examined");

endmodule

@@ sv/u8v_dp.sv @@
`timescale 1ns / 1ps
// Datapath: byte buffer, UTF-8 judgement, offset and error tracking, output register.
// Depends on u8v_pkg and u8v_out_if.
module u8v_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  u8v_pkg::u8v_cmd_t cmd,
  output u8v_pkg::u8v_stat_t stat,
  u8v_out_if.source         dout
);

  logic [7:0]                       buf_q [u8v_pkg::BUF_DEPTH];
  logic [2:0]                       count;
  logic                             last_q;
  logic [u8v_pkg::OFFSET_WIDTH-1:0] offset;
  logic                             error_seen;
  logic [u8v_pkg::OFFSET_WIDTH-1:0] first_err;

  logic                             out_valid;
  logic [7:0]                       out_byte_q;
  logic                             out_repl_q;
  logic                             out_last_q;
  logic                             out_ok_q;
  logic [u8v_pkg::OUT_OFS_W-1:0]    out_ofs_q;

  u8v_pkg::verdict_t                verdict;
  logic [2:0]                       need;
  logic [2:0]                       adv_len;
  logic                             drains;
  logic                             fin;
  logic [7:0]                       emit_byte;
  logic                             err_now;
  logic [u8v_pkg::OFFSET_WIDTH-1:0] ofs_after;
  logic [u8v_pkg::OFFSET_WIDTH-1:0] ofs_report;

  // judge the buffered bytes: lead class, continuations, overlong and surrogate checks
  always_comb begin
    logic bad;
    logic [7:0] lead;
    lead = buf_q[0];
    bad  = 1'b0;
    need = 3'd1;
    if (!lead[7]) begin
      need = 3'd1;
    end else if (lead[7:6] == u8v_pkg::CONT_TAG) begin
      bad = 1'b1;
    end else if (lead[7:5] == 3'b110) begin
      need = 3'd2;
      if (lead[4:1] == 4'd0) bad = 1'b1;
    end else if (lead[7:4] == 4'b1110) begin
      need = 3'd3;
    end else if (lead[7:3] == 5'b11110) begin
      need = 3'd4;
    end else begin
      bad = 1'b1;
    end
    for (int i = 1; i < u8v_pkg::BUF_DEPTH; i++) begin
      if (3'(i) < count && 3'(i) < need && buf_q[i][7:6] != u8v_pkg::CONT_TAG) bad = 1'b1;
    end
    if (count >= 3'd2) begin
      // three-byte overlong below U+0800
      if (need == 3'd3 && lead[3:0] == 4'd0 && !buf_q[1][5]) bad = 1'b1;
      // surrogates
      if (lead == u8v_pkg::SURR_LEAD && buf_q[1] >= u8v_pkg::SURR_LO &&
          buf_q[1] <= u8v_pkg::SURR_HI) bad = 1'b1;
      // four-byte overlong below U+10000
      if (need == 3'd4 && lead[2:0] == 3'd0 && buf_q[1][5:4] == 2'd0) bad = 1'b1;
    end
    if (count == 3'd0) begin
      verdict = u8v_pkg::V_NEED;
    end else if (bad) begin
      verdict = u8v_pkg::V_BAD;
    end else if (count < need) begin
      // a sequence cut short by the end mark fails
      verdict = last_q ? u8v_pkg::V_BAD : u8v_pkg::V_NEED;
    end else begin
      verdict = u8v_pkg::V_GOOD;
    end
  end

  // a failure consumes only its lead
  assign adv_len = (verdict == u8v_pkg::V_BAD) ? 3'd1 : need;
  assign drains  = (adv_len >= count);
  assign fin     = cmd.emit_end && last_q && drains;

  assign stat.verdict  = verdict;
  assign stat.seq_len  = need;
  assign stat.drains   = drains;
  assign stat.out_free = !out_valid || dout.ready;

  // output byte select
  always_comb begin
    if (verdict == u8v_pkg::V_BAD) begin
      case (cmd.idx)
        2'd0:    emit_byte = u8v_pkg::REPL_B0;
        2'd1:    emit_byte = u8v_pkg::REPL_B1;
        default: emit_byte = u8v_pkg::REPL_B2;
      endcase
    end else begin
      emit_byte = buf_q[cmd.idx];
    end
  end

  // string status as it stands after this sequence
  assign err_now    = error_seen || (verdict == u8v_pkg::V_BAD);
  assign ofs_after  = offset + u8v_pkg::OFFSET_WIDTH'(adv_len);
  assign ofs_report = error_seen ? first_err :
                      (verdict == u8v_pkg::V_BAD) ? offset : ofs_after;

  // buffer, offset and error state
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= 3'd0;
      last_q     <= 1'b0;
      offset     <= '0;
      error_seen <= 1'b0;
      first_err  <= '0;
    end else if (cmd.take) begin
      buf_q[count[1:0]] <= in_byte;
      count             <= count + 3'd1;
      last_q            <= in_last;
    end else if (cmd.emit_end) begin
      for (int i = 0; i < u8v_pkg::BUF_DEPTH; i++) begin
        if (i + int'(adv_len) < u8v_pkg::BUF_DEPTH) buf_q[i] <= buf_q[i + int'(adv_len)];
      end
      if (fin) begin
        count      <= 3'd0;
        last_q     <= 1'b0;
        offset     <= '0;
        error_seen <= 1'b0;
        first_err  <= '0;
      end else begin
        count  <= count - adv_len;
        offset <= ofs_after;
        if (verdict == u8v_pkg::V_BAD && !error_seen) begin
          error_seen <= 1'b1;
          first_err  <= offset;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_q <= emit_byte;
      out_repl_q <= (verdict == u8v_pkg::V_BAD);
      out_last_q <= fin;
      out_ok_q   <= fin && !err_now;
      out_ofs_q  <= fin ? u8v_pkg::OUT_OFS_W'(ofs_report) : '0;
    end
  end

  assign dout.valid            = out_valid;
  assign dout.out_byte         = out_byte_q;
  assign dout.is_replacement   = out_repl_q;
  assign dout.out_last         = out_last_q;
  assign dout.all_valid        = out_ok_q;
  assign dout.first_bad_offset = out_ofs_q;

  // a word is only taken when the buffer has room
  a_room: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> count < 3'(u8v_pkg::BUF_DEPTH))
    else $error("buffer overflow");

  // a word is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || dout.ready))
    else $error("output word overwritten");

  // the end of a string leaves clean state for the next one
  a_string_end: assert property (@(posedge clk) disable iff (rst)
    fin |=> (count == 3'd0 && offset == '0 && !error_seen && !last_q))
    else $error("string state not cleared");

endmodule

@@ sv/utf8_lossy_validator.sv @@
`timescale 1ns / 1ps
// Top level of the UTF-8 lossy validator: controller plus datapath.
// Depends on u8v_pkg, u8v_in_if, u8v_out_if, u8v_ctrl and u8v_dp.
//
//  channel  dir  handshake    word
//  din      in   valid/ready  in_byte, in_last
//  dout     out  valid/ready  out_byte, is_replacement, out_last, all_valid, first_bad_offset
//
// Each input word is loaded into the buffer and judged in the cycle after; each output word
// goes through the output register. The controller sets the pace: input is taken only while
// it is idle, never while the words of a judged sequence are being written.
// Synchronous active-high reset clears the buffer count, offset and error state.
// A stalled output holds its word; din is not ready while buffered words are being written.
module utf8_lossy_validator (
  input  logic      clk,
  input  logic      rst,
  u8v_in_if.sink    din,
  u8v_out_if.source dout
);

  u8v_pkg::u8v_cmd_t  cmd;
  u8v_pkg::u8v_stat_t stat;
  logic               in_ready;

  assign din.ready = in_ready;

  u8v_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  u8v_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_byte (din.in_byte),
    .in_last (din.in_last),
    .cmd     (cmd),
    .stat    (stat),
    .dout    (dout)
  );

endmodule
